// ----- design/dominated_vertex_hausdorff_search_assert.svh -----
// Assertion macros shared by the search block.
`ifndef DOMINATED_VERTEX_HAUSDORFF_SEARCH_ASSERT_SVH
`define DOMINATED_VERTEX_HAUSDORFF_SEARCH_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DVHS_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after the condition.
`define DVHS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- design/dvhs_pkg.sv -----
package dvhs_pkg;
  localparam int MAX_POINTS = 256;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] CMD_LOAD_X = 2'd0;
  localparam logic [1:0] CMD_LOAD_Y = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_RUN    = 2'd3;

  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;
  localparam logic [1:0] ST_RESULT  = 2'd3;

  localparam logic [2:0] KIND_LEVEL  = 3'd1;
  localparam logic [2:0] KIND_SEARCH = 3'd4;

  localparam int VTX_W = 5 * 32;
  localparam int YREC_W = VTX_W + 3;

  typedef struct packed {
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic signed [31:0] ca;
    logic signed [31:0] cb;
    logic signed [31:0] lvl;
  } vtx_t;

  typedef struct packed {
    vtx_t       v;
    logic [2:0] kind;
  } yrec_t;

  function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    absdiff = d[32] ? 33'(-d) : d;
  endfunction
endpackage

// ----- design/dvhs_if.sv -----
interface dvhs_in_if;
  import dvhs_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] coord_first;
  logic signed [31:0] coord_second;
  logic signed [31:0] cross_a;
  logic signed [31:0] cross_b;
  logic signed [31:0] level;
  logic [2:0]         vertex_kind;
  modport source (output valid, command, coord_first, coord_second, cross_a, cross_b,
                  level, vertex_kind, input ready);
  modport sink (input valid, command, coord_first, coord_second, cross_a, cross_b,
                level, vertex_kind, output ready);
endinterface

interface dvhs_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] distance;
  logic [1:0]  status;
  modport source (output valid, distance, status, input ready);
  modport sink (input valid, distance, status, output ready);
endinterface

interface dvhs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- design/dominated_vertex_hausdorff_search.sv -----
// Dominated-vertex Hausdorff search.
// Channels: in (command and vertex fields), out (distance, status), cfg
// (tie tolerance). Every accepted input word yields exactly one output word.
// Loads and clears answer in the cycle after acceptance: the result word is
// valid in the next cycle. A run first insertion-sorts Y through the rank
// memory (about n*n/2 read-compare-move steps), then for each X vertex walks
// the rank list at most once (rank read, Y read and check states per Y vertex)
// and, where only kind-4 vertices form the frontier, one more walk per frontier
// vertex. Run time is set by the single read port of each memory.
// Input ready is low while the result register holds a word, so a new word
// waits until the receiver has taken the last result. Reset empties both
// sets and sets tolerance to 1; the vertex memories need no clearing pass. A
// stalled receiver simply holds the result register and, through it, the
// whole block.
module dominated_vertex_hausdorff_search
  import dvhs_pkg::*;
(
  input logic     clk,
  input logic     rst,
  dvhs_in_if.sink   in_ch,
  dvhs_out_if.source out_ch,
  dvhs_cfg_if.sink  cfg
);
`include "dominated_vertex_hausdorff_search_assert.svh"

  localparam logic [4:0] S_IDLE = 5'd0, S_SORT_RD = 5'd1, S_SORT_CMP = 5'd2,
    S_X_RD = 5'd3, S_X_WAIT = 5'd4, S_SC_RD = 5'd5, S_SC_YRD = 5'd6,
    S_SC_CHK = 5'd7, S_EVAL_RD = 5'd8, S_EVAL = 5'd9, S_FK_RD = 5'd10,
    S_FK_YRD = 5'd11, S_FK_GET = 5'd12, S_PR_RD = 5'd13, S_PR_YRD = 5'd14,
    S_PR_CHK = 5'd15, S_PR_BRD = 5'd16, S_PR_BEST = 5'd17, S_NEXT_X = 5'd18,
    S_DONE = 5'd19, S_SORT_MV = 5'd20;

  logic [4:0] state;
  logic [CNT_W-1:0] x_total, y_total;
  logic [15:0] tol;
  logic out_full;

  // memory ports
  logic x_we, y_we, r_we, f_we;
  logic [IDX_W-1:0] x_wa, x_ra, y_wa, y_ra, r_wa, r_ra, f_wa, f_ra;
  vtx_t x_wd, x_rd;
  yrec_t y_wd, y_rd;
  logic [IDX_W-1:0] r_wd, r_rd, f_wd, f_rd;

  dvhs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_POINTS)) u_x (.clk, .we(x_we), .waddr(x_wa),
    .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
  dvhs_ram #(.WIDTH(YREC_W), .DEPTH(MAX_POINTS)) u_y (.clk, .we(y_we), .waddr(y_wa),
    .wdata(y_wd), .raddr(y_ra), .rdata(y_rd));
  dvhs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_rank (.clk, .we(r_we), .waddr(r_wa),
    .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  dvhs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_front (.clk, .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  // working registers
  logic [CNT_W-1:0] n, q, xi, p, nf, fi;
  yrec_t cur, kv;
  vtx_t xv;
  logic max_ok;
  logic signed [31:0] max_y;
  logic any;
  logic signed [33:0] h, h0;
  logic fx, fy;
  logic [32:0] bx, by;
  logic [IDX_W-1:0] px, py, j;

  assign in_ch.ready = (state == S_IDLE) && !out_full;
  assign cfg.ready = 1'b1;
  assign out_ch.valid = out_full;

  wire acc = in_ch.valid && in_ch.ready;

  // combinational helpers
  wire [32:0] tol33 = 33'(tol);
  function automatic logic before_f(input vtx_t a, input vtx_t b, input logic [32:0] t);
    if (absdiff(a.first, b.first) > t) before_f = a.first > b.first;
    else before_f = a.second > b.second;
  endfunction
  function automatic logic signed [33:0] cross_f(input vtx_t x, input vtx_t y);
    if (34'(x.first) + 34'(y.second) < 34'(y.first) + 34'(x.second))
      cross_f = $signed({1'b0, absdiff(x.ca, y.ca)});
    else cross_f = $signed({1'b0, absdiff(x.cb, y.cb)});
  endfunction
  function automatic logic [32:0] cheb(input vtx_t x, input vtx_t y);
    logic [32:0] d0, d1;
    d0 = absdiff(x.first, y.first);
    d1 = absdiff(x.second, y.second);
    cheb = d0 > d1 ? d0 : d1;
  endfunction

  wire signed [33:0] ks_m_t = 34'(kv.v.second) - 34'(tol);
  wire signed [33:0] kf_m_t = 34'(kv.v.first) - 34'(tol);
  wire ax1 = absdiff(y_rd.v.second, kv.v.second) < tol33 && 34'(y_rd.v.first) < kf_m_t;
  wire ax2 = absdiff(y_rd.v.first, kv.v.first) < tol33 && 34'(y_rd.v.second) < ks_m_t;
  wire [32:0] dch = cheb(xv, y_rd.v);

  always_comb begin
    x_we = 1'b0; x_wa = x_total[IDX_W-1:0]; x_wd = vtx_t'(0);
    y_we = 1'b0; y_wa = y_total[IDX_W-1:0]; y_wd = yrec_t'(0);
    r_we = 1'b0; r_wa = q[IDX_W-1:0]; r_wd = r_rd;
    f_we = 1'b0; f_wa = nf[IDX_W-1:0]; f_wd = j;
    x_ra = xi[IDX_W-1:0];
    y_ra = r_rd;
    r_ra = p[IDX_W-1:0];
    f_ra = fi[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        x_wd = '{in_ch.coord_first, in_ch.coord_second, in_ch.cross_a, in_ch.cross_b,
                 in_ch.level};
        y_wd = '{x_wd, in_ch.vertex_kind};
        x_we = acc && in_ch.command == CMD_LOAD_X && x_total < CNT_W'(MAX_POINTS);
        y_we = acc && in_ch.command == CMD_LOAD_Y && y_total < CNT_W'(MAX_POINTS);
        y_ra = n[IDX_W-1:0];
      end
      S_SORT_RD: begin
        // q takes n at this edge, so fetch rank[n-1] with ys[n]
        r_ra = IDX_W'(n - 1'b1);
        y_ra = n[IDX_W-1:0];
      end
      S_SORT_CMP: begin
        y_ra = r_rd;
        r_ra = IDX_W'(q - 1'b1);
      end
      S_SORT_MV: begin
        // y_rd holds ys[rank[q-1]]; r_rd still holds rank[q-1]
        r_we = 1'b1;
        if (q != '0 && before_f(cur.v, y_rd.v, tol33)) r_wd = r_rd;
        else r_wd = n[IDX_W-1:0];
        r_ra = IDX_W'(q - 2'd2);
      end
      S_SC_CHK: begin
        f_we = (xv.first > y_rd.v.first && xv.second > y_rd.v.second) &&
               (!max_ok || y_rd.v.second > max_y) && y_rd.kind == KIND_SEARCH;
        f_wd = r_rd;
      end
      S_EVAL_RD: y_ra = j;
      S_FK_YRD: y_ra = f_rd;
      S_PR_BRD: y_ra = (fx && (!fy || bx <= by)) ? px : py;
      default: ;
    endcase
  end

  // sequential control; S_SORT_CMP re-reads rank[q-1] so r_rd stays valid for the sort-move
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; x_total <= '0; y_total <= '0; tol <= 16'd1; out_full <= 1'b0;
    end else begin
      if (cfg.valid) tol <= cfg.data;
      if (out_ch.valid && out_ch.ready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            out_full <= (in_ch.command != CMD_RUN);
            out_ch.distance <= '0;
            case (in_ch.command)
              CMD_LOAD_X: begin
                if (x_total < CNT_W'(MAX_POINTS)) begin
                  x_total <= x_total + 1'b1; out_ch.status <= ST_LOADED;
                end else out_ch.status <= ST_DROPPED;
              end
              CMD_LOAD_Y: begin
                if (y_total < CNT_W'(MAX_POINTS)) begin
                  y_total <= y_total + 1'b1; out_ch.status <= ST_LOADED;
                end else out_ch.status <= ST_DROPPED;
              end
              CMD_CLEAR: begin
                x_total <= '0; y_total <= '0; out_ch.status <= ST_CLEARED;
              end
              default: begin
                h <= '0; n <= '0; xi <= '0;
                state <= S_SORT_RD;
              end
            endcase
          end
        end
        S_SORT_RD: begin
          if (n == y_total) state <= S_X_RD;
          else begin
            q <= n; state <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          // r_rd = rank[q-1]; y_rd = ys[n] only on entry from S_SORT_RD, when q == n
          if (q == n) cur <= y_rd;
          state <= S_SORT_MV;
        end
        S_SORT_MV: begin
          if (q != '0 && before_f(cur.v, y_rd.v, tol33)) begin
            q <= q - 1'b1; state <= S_SORT_CMP;
          end else begin
            n <= n + 1'b1; state <= S_SORT_RD;
          end
        end
        S_X_RD: begin
          if (xi == x_total) state <= S_DONE;
          else state <= S_X_WAIT;
        end
        S_X_WAIT: begin
          xv <= x_rd; p <= '0; nf <= '0; max_ok <= 1'b0; state <= S_SC_RD;
        end
        S_SC_RD: begin
          if (p == y_total) state <= (nf == '0) ? S_NEXT_X : S_FK_RD;
          else state <= S_SC_YRD;
          h0 <= 34'(xv.lvl); any <= 1'b0; fi <= '0;
        end
        S_SC_YRD: state <= S_SC_CHK;
        S_SC_CHK: begin
          state <= S_SC_RD; p <= p + 1'b1;
          if (xv.first > y_rd.v.first && xv.second > y_rd.v.second &&
              (!max_ok || y_rd.v.second > max_y)) begin
            max_ok <= 1'b1; max_y <= y_rd.v.second;
            if (y_rd.kind != KIND_SEARCH) begin
              j <= r_rd; state <= S_EVAL_RD;
            end else nf <= nf + 1'b1;
          end
        end
        S_EVAL_RD: state <= S_EVAL;
        S_EVAL: begin
          if (y_rd.kind == KIND_LEVEL) h0 <= $signed({1'b0, absdiff(xv.lvl, y_rd.v.lvl)});
          else h0 <= cross_f(xv, y_rd.v);
          state <= S_NEXT_X;
        end
        S_FK_RD: begin
          if (fi == nf) state <= S_NEXT_X;
          else state <= S_FK_YRD;
        end
        S_FK_YRD: state <= S_FK_GET;
        S_FK_GET: begin
          kv <= y_rd; p <= '0; fx <= 1'b0; fy <= 1'b0; state <= S_PR_RD;
        end
        S_PR_RD: begin
          if (p == y_total) state <= (fx || fy) ? S_PR_BRD : S_FK_RD;
          else state <= S_PR_YRD;
          if (p == y_total) fi <= fi + 1'b1;
        end
        S_PR_YRD: state <= S_PR_CHK;
        S_PR_CHK: begin
          if (ax1 && (!fx || dch < bx)) begin
            bx <= dch; px <= r_rd; fx <= 1'b1;
          end
          if (ax2 && (!fy || dch < by)) begin
            by <= dch; py <= r_rd; fy <= 1'b1;
          end
          p <= p + 1'b1; state <= S_PR_RD;
        end
        S_PR_BRD: state <= S_PR_BEST;
        S_PR_BEST: begin
          if (!any || cross_f(xv, y_rd.v) < h0) h0 <= cross_f(xv, y_rd.v);
          any <= 1'b1; state <= S_FK_RD;
        end
        S_NEXT_X: begin
          if (h0 > h) h <= h0;
          xi <= xi + 1'b1; state <= S_X_RD;
        end
        S_DONE: begin
          out_full <= 1'b1; out_ch.status <= ST_RESULT;
          out_ch.distance <= (h > 34'sd2147483647) ? 31'h7FFFFFFF : h[30:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DVHS_ASSERT_IMP(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE,
    "input taken outside idle")
  `DVHS_ASSERT_IMP(a_counts, clk, rst, 1'b1,
    x_total <= CNT_W'(MAX_POINTS) && y_total <= CNT_W'(MAX_POINTS), "count overflow")
  `DVHS_ASSERT_NEXT(a_load_result, clk, rst, acc && in_ch.command != CMD_RUN, out_full,
    "load gave no result")
endmodule

// ----- design/dvhs_ram.sv -----
module dvhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sim/dvhs_scoreboard.sv -----
`timescale 1ns / 100ps

module dvhs_scoreboard
  import dvhs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dvhs_in_if   in_ch,
  dvhs_out_if  out_ch,
  dvhs_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);

  localparam longint SAT_LIMIT = 64'sd2147483647;

  typedef struct {
    longint f, s, a, b, l;
  } point_t;

  typedef struct packed {
    logic [30:0] span;
    logic [1:0]  st;
  } answer_t;

  point_t     xp[MAX_POINTS];
  point_t     yp[MAX_POINTS];
  logic [2:0] ykind[MAX_POINTS];
  int         order[MAX_POINTS];
  int         nx, ny;
  longint     tol;
  answer_t    due[$];

  function automatic longint gap(longint p, longint q);
    return p > q ? p - q : q - p;
  endfunction

  function automatic bit precedes(point_t p, point_t q);
    if (gap(p.f, q.f) > tol) return p.f > q.f;
    return p.s > q.s;
  endfunction

  function automatic longint cross_gap(point_t x, point_t y);
    if (x.f + y.s < y.f + x.s) return gap(x.a, y.a);
    return gap(x.b, y.b);
  endfunction

  function automatic longint cheb(point_t x, point_t y);
    longint d0, d1;
    d0 = gap(x.f, y.f);
    d1 = gap(x.s, y.s);
    return d0 > d1 ? d0 : d1;
  endfunction

  // Distance of one X vertex against the ordered Y set.
  function automatic longint vertex_h(point_t x);
    bit     seen, found, fa, fb;
    longint top, h0, ba, bb, d, cand;
    int     nf, stop, j, pa, pb, pick;
    int     fr[MAX_POINTS];
    point_t k;
    seen = 0; found = 0; top = 0; h0 = x.l; nf = 0; stop = -1;
    for (int p = 0; p < ny; p++) begin
      j = order[p];
      if (x.f > yp[j].f && x.s > yp[j].s && (!seen || yp[j].s > top)) begin
        seen = 1;
        top = yp[j].s;
        if (ykind[j] != KIND_SEARCH) begin
          stop = j;
          break;
        end
        fr[nf] = j;
        nf++;
      end
    end
    if (stop >= 0) begin
      if (ykind[stop] == KIND_LEVEL) return gap(x.l, yp[stop].l);
      return cross_gap(x, yp[stop]);
    end
    if (nf == 0) return x.l;
    for (int f = 0; f < nf; f++) begin
      k = yp[fr[f]];
      fa = 0; fb = 0; ba = 0; bb = 0; pa = 0; pb = 0;
      for (int p = 0; p < ny; p++) begin
        j = order[p];
        if (gap(yp[j].s, k.s) < tol && yp[j].f < k.f - tol) begin
          d = cheb(x, yp[j]);
          if (!fa || d < ba) begin ba = d; pa = j; fa = 1; end
        end
        if (gap(yp[j].f, k.f) < tol && yp[j].s < k.s - tol) begin
          d = cheb(x, yp[j]);
          if (!fb || d < bb) begin bb = d; pb = j; fb = 1; end
        end
      end
      if (fa || fb) begin
        pick = (fa && (!fb || ba <= bb)) ? pa : pb;
        cand = cross_gap(x, yp[pick]);
        if (!found || cand < h0) h0 = cand;
        found = 1;
      end
    end
    return found ? h0 : x.l;
  endfunction

  function automatic longint search_result();
    int     q;
    longint h, h0;
    // stable insertion sort of Y, rebuilt on every run
    for (int n = 0; n < ny; n++) begin
      q = n;
      while (q > 0 && precedes(yp[n], yp[order[q-1]])) begin
        order[q] = order[q-1];
        q--;
      end
      order[q] = n;
    end
    h = 0;
    for (int i = 0; i < nx; i++) begin
      h0 = vertex_h(xp[i]);
      if (h0 > h) h = h0;
    end
    return h > SAT_LIMIT ? SAT_LIMIT : h;
  endfunction

  task automatic flag(string what, answer_t exp, answer_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected distance %h status %0d, got distance %h status %0d",
               $realtime, what, exp.span, exp.st, got.span, got.st);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    point_t  v;
    answer_t exp, got;
    if (rst) begin
      nx = 0;
      ny = 0;
      tol = 1;
      due.delete();
    end else begin
      if (cfg.valid && cfg.ready) tol = longint'(cfg.data);
      if (in_ch.valid && in_ch.ready) begin
        v.f = in_ch.coord_first;
        v.s = in_ch.coord_second;
        v.a = in_ch.cross_a;
        v.b = in_ch.cross_b;
        v.l = in_ch.level;
        exp = '{span: '0, st: ST_LOADED};
        case (in_ch.command)
          CMD_LOAD_X: begin
            if (nx >= MAX_POINTS) exp.st = ST_DROPPED;
            else begin xp[nx] = v; nx++; end
          end
          CMD_LOAD_Y: begin
            if (ny >= MAX_POINTS) exp.st = ST_DROPPED;
            else begin
              yp[ny] = v;
              ykind[ny] = in_ch.vertex_kind;
              ny++;
            end
          end
          CMD_CLEAR: begin
            nx = 0;
            ny = 0;
            exp.st = ST_CLEARED;
          end
          default: begin
            exp.span = 31'(search_result());
            exp.st = ST_RESULT;
          end
        endcase
        due = {due, exp};
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{span: out_ch.distance, st: out_ch.status};
        if (due.size() == 0) flag("word with nothing due", '0, got);
        else begin
          exp = due.pop_front();
          if (got !== exp) flag("mismatch", exp, got);
        end
      end
    end
    pending = due.size();
  end

endmodule

// ----- sim/dominated_vertex_hausdorff_search_tb.sv -----
`timescale 1ns / 100ps

module dominated_vertex_hausdorff_search_tb;
  import dvhs_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] f, s, a, b, l;
    logic [2:0]         k;
  } word_t;

  logic clk;
  logic rst;
  int   fail_count, pending;
  int   burst_left;
  int   items_sent;
  bit   long_hold;

  dvhs_in_if  in_ch();
  dvhs_out_if out_ch();
  dvhs_cfg_if cfg();

  dominated_vertex_hausdorff_search uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  dvhs_scoreboard checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run, reporting a mismatch, once it runs past CYCLE_LIMIT, as when the block stops answering.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: redraw the stall pattern from open, mostly ready and coin-flip
  // modes, so stalls hit every phase of the work, with some fully open stretches.
  always @(posedge clk) begin
    int mode_left, mode;
    if (rst) begin
      out_ch.ready <= 1'b0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = 64;
      end
      mode_left--;
      if (long_hold) out_ch.ready <= 1'b0;
      else if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= 1'($urandom_range(0, 1));
    end
  end

  // Long receiver hold-off while the sender keeps offering words, so the
  // result register fills and the input stalls.
  initial begin
    long_hold = 0;
    @(negedge rst);
    repeat (600) @(posedge clk);
    long_hold = 1;
    repeat (500) @(posedge clk);
    long_hold = 0;
  end

  // Offer one word and hold it until taken; sometimes open a gap between bursts.
  task automatic send(word_t w);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      g = $urandom_range(0, 5);
      if (g > 0) begin
        in_ch.valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.command      <= w.cmd;
    in_ch.coord_first  <= w.f;
    in_ch.coord_second <= w.s;
    in_ch.cross_a      <= w.a;
    in_ch.cross_b      <= w.b;
    in_ch.level        <= w.l;
    in_ch.vertex_kind  <= w.k;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  function automatic word_t vertex(logic [1:0] cmd, int f, int s, int a, int b, int l,
                                   logic [2:0] k);
    word_t w;
    w = '{cmd: cmd, f: f, s: s, a: a, b: b, l: l, k: k};
    return w;
  endfunction

  // Coordinates mostly on a coarse grid with tiny jitter, so dominance and
  // tolerance ties are common; sometimes full-range or extreme values.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return ($urandom_range(0, 10) - 5) * 65536 + $urandom_range(0, 2);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 8) * 65536;
    return $urandom;
  endfunction

  function automatic word_t random_vertex(logic [1:0] cmd);
    word_t w;
    w.cmd = cmd;
    w.f = pick_coord();
    w.s = pick_coord();
    w.a = pick_value();
    w.b = pick_value();
    w.l = pick_value();
    w.k = ($urandom_range(0, 9) < 7) ? KIND_SEARCH : 3'($urandom_range(0, 7));
    return w;
  endfunction

  // Let a clock edge pass first so the checker has counted the last accepted word.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(negedge clk);
    while (!cfg.ready) @(negedge clk);
    @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One well-formed set: clear, load small X and Y sets in random
  // interleaving, run. Noise words are single random commands.
  task automatic random_phase(int count);
    int start, nx, ny;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 99) < 85) begin
        send(vertex(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                    3'($urandom_range(0, 7))));
        nx = $urandom_range(0, 7);
        ny = $urandom_range(0, 10);
        while (nx + ny > 0) begin
          if (ny == 0 || (nx > 0 && $urandom_range(0, 1))) begin
            send(random_vertex(CMD_LOAD_X));
            nx--;
          end else begin
            send(random_vertex(CMD_LOAD_Y));
            ny--;
          end
        end
        send(random_vertex(CMD_RUN));
      end else begin
        send(random_vertex(2'($urandom_range(0, 3))));
      end
    end
  endtask

  localparam int Q1 = 65536;

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_LOAD_X;
    in_ch.coord_first <= '0;
    in_ch.coord_second <= '0;
    in_ch.cross_a <= '0;
    in_ch.cross_b <= '0;
    in_ch.level <= '0;
    in_ch.vertex_kind <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    burst_left = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty run, saturated level, level difference overflow,
    // negative distance, cross rule both ways, kind-4 predecessor search.
    send(vertex(CMD_RUN, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_LOAD_X, 10 * Q1, 10 * Q1, 0, 0, 32'h7FFFFFFF, 0));
    send(vertex(CMD_RUN, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_LOAD_Y, Q1, Q1, 0, 0, 32'h80000000, KIND_LEVEL));
    send(vertex(CMD_RUN, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_LOAD_X, 0, 0, 0, 0, -5 * Q1, 0));
    send(vertex(CMD_RUN, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_LOAD_X, 5 * Q1, 5 * Q1, 32'h7FFFFFFF, -3 * Q1, 0, 0));
    send(vertex(CMD_LOAD_X, 6 * Q1, 9 * Q1, 2 * Q1, 7 * Q1, 0, 0));
    send(vertex(CMD_LOAD_Y, Q1, 2 * Q1, 32'h80000000, Q1, 0, 2));
    send(vertex(CMD_RUN, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_LOAD_X, 9 * Q1, 9 * Q1, 3 * Q1, 4 * Q1, Q1, 0));
    send(vertex(CMD_LOAD_Y, 4 * Q1, 4 * Q1, 0, 0, 0, KIND_SEARCH));
    send(vertex(CMD_LOAD_Y, 2 * Q1, 4 * Q1, Q1, 9 * Q1, 0, 0));
    send(vertex(CMD_LOAD_Y, 4 * Q1, 2 * Q1, 8 * Q1, 0, 0, 7));
    send(vertex(CMD_LOAD_Y, 8 * Q1, 3 * Q1, 0, 0, 0, KIND_SEARCH));
    send(vertex(CMD_RUN, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_LOAD_Y, 20 * Q1, 20 * Q1, 0, 0, 0, 3));
    send(vertex(CMD_RUN, 0, 0, 0, 0, 0, 0));
    send(vertex(CMD_CLEAR, 0, 0, 0, 0, 0, 0));

    // Fill the X set past the top to see a dropped load; never run on it.
    for (int i = 0; i <= MAX_POINTS; i++) send(random_vertex(CMD_LOAD_X));
    send(vertex(CMD_CLEAR, 0, 0, 0, 0, 0, 0));

    random_phase(30);
    drain();
    write_tolerance(16'd0);
    random_phase(30);
    drain();
    write_tolerance(16'hFFFF);
    random_phase(30);
    drain();
    write_tolerance(16'($urandom_range(2, 4000)));
    random_phase(30);
    drain();
    write_tolerance(16'd1);
    random_phase(30);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
